>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/pat_pkg.sv
package pat_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int AVAIL_W = 48;
  localparam logic [31:0] RATE_RESET = 32'h0001_0000;
  localparam logic [AVAIL_W-1:0] AVAIL_MAX = {AVAIL_W{1'b1}};

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [31:0] point_time;
    logic [31:0] amount;
  } entry_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] point_time;
    logic [31:0] amount;
    logic [31:0] current_time;
  } req_t;

  typedef struct packed {
    logic [AVAIL_W-1:0] availability;
    logic               status;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_WRITE,
    ST_MUL,
    ST_ADD,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

>>> design/piecewise_availability_table.sv
// Channel  Direction  Transaction
// s_*      in         one query or insert request
// m_*      out        one result per request
// cfg_*    in         write of rate_per_tick
//
// A request walks the sorted table one entry per cycle from the single read port.
// A query scans the n entries before the deadline, then passes the multiply, add and finish states.
// An insert shifts each later entry up before its write, a replace writes in place, and an insert
// dropped on a full table skips both. The next request is accepted once the core is idle again.
// Reset empties the table at once; entry contents are undefined until written.
// A result waits in the output register; the next request is accepted while it waits.
module piecewise_availability_table #(
  parameter int TABLE_DEPTH = pat_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // point_time, amount, current_time
  input  logic [0:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // availability
  output logic [0:0]  m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0]   rate;
  pat_pkg::req_t req;
  pat_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= pat_pkg::RATE_RESET;
    end else if (cfg_valid) begin
      rate <= cfg_data;
    end
  end

  assign req.operation    = s_tuser[0];
  assign req.point_time   = s_tdata[31:0];
  assign req.amount       = s_tdata[63:32];
  assign req.current_time = s_tdata[95:64];

  pat_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .rate      (rate),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_out   (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata    <= res.availability;
      m_tuser[0] <= res.status;
    end
  end

endmodule

>>> design/pat_table.sv
module pat_table #(
  parameter int TABLE_DEPTH = pat_pkg::TABLE_DEPTH_DEF,
  localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  pat_pkg::entry_t      wr_entry,
  input  logic [IDX_W-1:0]     rd_addr,
  output pat_pkg::entry_t      rd_entry
);

  pat_pkg::entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

endmodule

>>> design/pat_core.sv
`include "assert_macros.svh"

module pat_core #(
  parameter int TABLE_DEPTH = pat_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [31:0]    rate,
  input  logic           req_valid,
  output logic           req_ready,
  input  pat_pkg::req_t  req,
  output logic           res_valid,
  input  logic           res_ready,
  output pat_pkg::res_t  res_out
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_W = 32 + CNT_W;
  localparam int RES_W = ((SUM_W > pat_pkg::AVAIL_W) ? SUM_W : pat_pkg::AVAIL_W) + 1;
  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(TABLE_DEPTH);

  pat_pkg::state_t state, state_next;

  logic              op;
  logic [31:0]       key;
  logic [31:0]       amt;
  logic [31:0]       start;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  cap;
  logic              have_cap;
  logic              replace;
  logic              dropped;
  logic [CNT_W-1:0]  i;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  k;
  logic [31:0]       elapsed;
  logic [63:0]       prod;
  logic [RES_W-1:0]  res;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  pat_pkg::entry_t   wr_entry;
  logic [IDX_W-1:0]  rd_addr;
  pat_pkg::entry_t   rd_entry;

  logic              more;
  logic              hit;
  logic              match;
  logic              full;
  logic [CNT_W-1:0]  i_inc;
  logic [CNT_W-1:0]  cnt_dec;
  logic [IDX_W-1:0]  k_dec;
  logic [IDX_W-1:0]  k_dec2;
  logic              shift_more;
  logic [RES_W-1:0]  capped;

  pat_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // The same comparators walk the sorted entries for both queries and inserts.
  assign more       = (i != count);
  assign hit        = more && (rd_entry.point_time < key);
  assign match      = more && (rd_entry.point_time == key);
  assign full       = (count == COUNT_MAX);
  assign i_inc      = i + 1'b1;
  assign cnt_dec    = count - 1'b1;
  assign k_dec      = k - 1'b1;
  assign k_dec2     = k_dec - 1'b1;
  assign shift_more = CNT_W'(k_dec) > i;

  always_comb begin
    capped = res;
    if (have_cap && (res > RES_W'(cap))) begin
      capped = RES_W'(cap);
    end
    if (capped > RES_W'(pat_pkg::AVAIL_MAX)) begin
      capped = RES_W'(pat_pkg::AVAIL_MAX);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pat_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = pat_pkg::ST_SCAN;
        end
      end
      pat_pkg::ST_SCAN: begin
        if (!hit) begin
          if (op == pat_pkg::OP_QUERY) begin
            state_next = pat_pkg::ST_MUL;
          end else if (match) begin
            state_next = pat_pkg::ST_WRITE;
          end else if (full) begin
            state_next = pat_pkg::ST_FIN;
          end else if (!more) begin
            state_next = pat_pkg::ST_WRITE;
          end else begin
            state_next = pat_pkg::ST_SHIFT;
          end
        end
      end
      pat_pkg::ST_SHIFT: begin
        if (!shift_more) begin
          state_next = pat_pkg::ST_WRITE;
        end
      end
      pat_pkg::ST_WRITE: state_next = pat_pkg::ST_FIN;
      pat_pkg::ST_MUL:   state_next = pat_pkg::ST_ADD;
      pat_pkg::ST_ADD:   state_next = pat_pkg::ST_FIN;
      pat_pkg::ST_FIN:   state_next = pat_pkg::ST_DONE;
      pat_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = pat_pkg::ST_IDLE;
        end
      end
      default: state_next = pat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = i[IDX_W-1:0];
    wr_entry  = '{point_time: key, amount: amt};
    rd_addr   = i[IDX_W-1:0];
    unique case (state)
      pat_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        rd_addr   = '0;
      end
      pat_pkg::ST_SCAN: begin
        rd_addr = hit ? i_inc[IDX_W-1:0] : cnt_dec[IDX_W-1:0];
      end
      pat_pkg::ST_SHIFT: begin
        wr_en    = 1'b1;
        wr_addr  = k;
        wr_entry = rd_entry;
        rd_addr  = k_dec2;
      end
      pat_pkg::ST_WRITE: begin
        wr_en = 1'b1;
      end
      pat_pkg::ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pat_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == pat_pkg::ST_WRITE && !replace) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pat_pkg::ST_IDLE: begin
        op    <= req.operation;
        key   <= req.point_time;
        amt   <= req.amount;
        start <= req.current_time;
        sum   <= '0;
        i     <= '0;
      end
      pat_pkg::ST_SCAN: begin
        if (hit) begin
          i     <= i_inc;
          sum   <= sum + SUM_W'(rd_entry.amount);
          start <= rd_entry.point_time;
        end else begin
          have_cap <= more;
          cap      <= sum + SUM_W'(rd_entry.amount);
          elapsed  <= (key > start) ? (key - start) : '0;
          replace  <= match;
          dropped  <= (op == pat_pkg::OP_INSERT) && !match && full;
          k        <= count[IDX_W-1:0];
        end
      end
      pat_pkg::ST_SHIFT: k <= k_dec;
      pat_pkg::ST_MUL:   prod <= 64'(rate) * 64'(elapsed);
      pat_pkg::ST_ADD:   res <= RES_W'(sum) + RES_W'(prod[63:16]);
      pat_pkg::ST_FIN: begin
        if (op == pat_pkg::OP_QUERY) begin
          res_out.availability <= capped[pat_pkg::AVAIL_W-1:0];
          res_out.status       <= pat_pkg::STATUS_OK;
        end else begin
          res_out.availability <= '0;
          res_out.status       <= dropped ? pat_pkg::STATUS_FULL : pat_pkg::STATUS_OK;
        end
      end
      default: begin
      end
    endcase
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= COUNT_MAX, "entry count above table depth")
  `ASSERT_ALWAYS(a_write_states, clk, rst, !wr_en || state == pat_pkg::ST_SHIFT || state == pat_pkg::ST_WRITE, "table written outside an insert")
  `ASSERT_NEXT(a_accept_scan, clk, rst, req_valid && req_ready, state == pat_pkg::ST_SCAN, "accepted item did not start a scan")
  `ASSERT_ALWAYS(a_shift_above_pos, clk, rst, state != pat_pkg::ST_SHIFT || CNT_W'(k) > i, "shift reached the insert position")

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = pat_pkg::TABLE_DEPTH_DEF;
  localparam int RANDOM_PER_PHASE = 215;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  piecewise_availability_table dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the point table and the rate register.
  logic [31:0] pt_time [DEPTH];
  logic [31:0] pt_amount [DEPTH];
  int          pt_count = 0;
  logic [31:0] rate_q16 = pat_pkg::RATE_RESET;

  pat_pkg::req_t request_queue [$];
  pat_pkg::res_t predicted_results [$];
  logic [31:0]   gen_times [$];
  pat_pkg::req_t presented;

  int pushed_count = 0;
  int accepted_count = 0;
  int results_seen = 0;
  int query_count = 0;
  int insert_count = 0;
  int drop_count = 0;
  int saturated_count = 0;
  int rate_writes = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  function automatic logic [47:0] availability_at(input logic [31:0] deadline,
                                                   input logic [31:0] now);
    logic [63:0] sum;
    logic [63:0] total;
    logic [63:0] cap;
    logic [31:0] start;
    logic [31:0] elapsed;
    int i;
    sum = '0;
    start = now;
    i = 0;
    while (i < pt_count && pt_time[i] < deadline) begin
      start = pt_time[i];
      sum = sum + 64'(pt_amount[i]);
      i++;
    end
    total = sum;
    if (deadline > start) begin
      elapsed = deadline - start;
      total = total + ((64'(rate_q16) * 64'(elapsed)) >> 16);
    end
    if (i < pt_count) begin
      cap = sum + 64'(pt_amount[i]);
      if (total > cap) total = cap;
    end
    if (total > 64'(pat_pkg::AVAIL_MAX)) begin
      saturated_count++;
      total = 64'(pat_pkg::AVAIL_MAX);
    end
    return total[47:0];
  endfunction

  function automatic logic place_point(input logic [31:0] t, input logic [31:0] a);
    int pos;
    pos = 0;
    while (pos < pt_count && pt_time[pos] < t) pos++;
    if (pos < pt_count && pt_time[pos] == t) begin
      pt_amount[pos] = a;
      return pat_pkg::STATUS_OK;
    end
    if (pt_count >= DEPTH) return pat_pkg::STATUS_FULL;
    for (int k = pt_count; k > pos; k--) begin
      pt_time[k] = pt_time[k-1];
      pt_amount[k] = pt_amount[k-1];
    end
    pt_time[pos] = t;
    pt_amount[pos] = a;
    pt_count++;
    return pat_pkg::STATUS_OK;
  endfunction

  function automatic void record_request(input pat_pkg::req_t rq);
    pat_pkg::res_t r;
    r.availability = '0;
    r.status = pat_pkg::STATUS_OK;
    if (rq.operation == pat_pkg::OP_QUERY) begin
      r.availability = availability_at(rq.point_time, rq.current_time);
      query_count++;
    end else begin
      r.status = place_point(rq.point_time, rq.amount);
      insert_count++;
      if (r.status == pat_pkg::STATUS_FULL) drop_count++;
    end
    predicted_results.push_back(r);
    accepted_count++;
  endfunction

  task automatic flag_mismatch(input string what, input logic [47:0] got,
                               input logic [47:0] want);
    $display("mismatch at result %0d: %s, got %h, expected %h",
             results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_request(input logic op, input logic [31:0] t,
                               input logic [31:0] a, input logic [31:0] now);
    pat_pkg::req_t rq;
    bit known;
    rq.operation = op;
    rq.point_time = t;
    rq.amount = a;
    rq.current_time = now;
    request_queue.push_back(rq);
    pushed_count++;
    if (op == pat_pkg::OP_INSERT) begin
      known = 1'b0;
      foreach (gen_times[i]) if (gen_times[i] == t) known = 1'b1;
      if (!known && gen_times.size() < DEPTH) gen_times.push_back(t);
    end
  endtask

  task automatic wait_for_drain();
    while (accepted_count != pushed_count || predicted_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_rate(input logic [31:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rate_q16 = value;
    rate_writes++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) record_request(presented);
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0 || request_queue.size() == 0) begin
          if (send_gap != 0) send_gap--;
          s_tvalid <= 1'b0;
        end else begin
          presented = request_queue.pop_front();
          s_tdata <= {presented.current_time, presented.amount, presented.point_time};
          s_tuser <= presented.operation;
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 8);
        end
      end
    end
  end

  always @(posedge clk) begin
    pat_pkg::res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          flag_mismatch("result with no request outstanding", m_tdata, '0);
        end else begin
          want = predicted_results.pop_front();
          if (m_tdata !== want.availability)
            flag_mismatch("availability", m_tdata, want.availability);
          if (m_tuser[0] !== want.status)
            flag_mismatch("status", 48'(m_tuser), 48'(want.status));
        end
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 8);
      end
      if (recv_gap != 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] phase_rates [8];
    logic [31:0] t;
    logic [31:0] a;
    logic [31:0] now;
    int pick;
    phase_rates = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                    32'h0000_0000, 32'h0000_8000, 32'h0000_0000, 32'h7FFF_FFFF};
    phase_rates[4] = $urandom();
    phase_rates[6] = $urandom();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty table, then a few points with a replace, clamps and a slope past the last point.
    queue_request(pat_pkg::OP_QUERY, 32'd100, 32'hFFFF_FFFF, 32'd40);
    queue_request(pat_pkg::OP_QUERY, 32'd0, 32'd0, 32'hFFFF_FFFF);
    queue_request(pat_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0);
    queue_request(pat_pkg::OP_INSERT, 32'd1000, 32'd500, 32'd0);
    queue_request(pat_pkg::OP_INSERT, 32'd1000, 32'd123, 32'hFFFF_FFFF);
    queue_request(pat_pkg::OP_INSERT, 32'd500, 32'd10, 32'd0);
    queue_request(pat_pkg::OP_QUERY, 32'd1000, 32'd0, 32'd0);
    queue_request(pat_pkg::OP_QUERY, 32'd750, 32'd0, 32'd0);
    queue_request(pat_pkg::OP_QUERY, 32'd2000, 32'd0, 32'd0);
    queue_request(pat_pkg::OP_QUERY, 32'd400, 32'd0, 32'd300);
    queue_request(pat_pkg::OP_QUERY, 32'd400, 32'd0, 32'd450);
    wait_for_drain();
    write_rate(32'hFFFF_FFFF);
    queue_request(pat_pkg::OP_INSERT, 32'd1, 32'hFFFF_FFFF, 32'd0);
    queue_request(pat_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'd0, 32'd0);
    queue_request(pat_pkg::OP_QUERY, 32'd1, 32'd0, 32'd0);
    queue_request(pat_pkg::OP_QUERY, 32'd0, 32'd0, 32'd0);

    for (int p = 0; p < 8; p++) begin
      wait_for_drain();
      write_rate(phase_rates[p]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(0, 19);
        if ($urandom_range(0, 1) == 0) begin
          if (pick < 8)
            t = $urandom();
          else if (pick < 14)
            t = gen_times[$urandom_range(0, gen_times.size() - 1)] + $urandom_range(0, 2) - 1;
          else if (pick < 17)
            t = gen_times[$urandom_range(0, gen_times.size() - 1)] + $urandom_range(0, 1 << 20);
          else
            t = $urandom_range(0, 3);
          case ($urandom_range(0, 3))
            0, 1: now = $urandom();
            2: now = 32'd0;
            default: now = t - $urandom_range(0, 64) + $urandom_range(0, 8);
          endcase
          queue_request(pat_pkg::OP_QUERY, t, $urandom(), now);
        end else begin
          if (gen_times.size() < DEPTH && $urandom_range(0, 39) == 0)
            t = (gen_times.size() == DEPTH - 1) ? 32'hFFFF_FFFF : $urandom();
          else if (gen_times.size() == DEPTH && $urandom_range(0, 3) == 0)
            t = $urandom();
          else
            t = gen_times[$urandom_range(0, gen_times.size() - 1)];
          case ($urandom_range(0, 7))
            0: a = 32'd0;
            1: a = 32'hFFFF_FFFF;
            default: a = $urandom();
          endcase
          queue_request(pat_pkg::OP_INSERT, t, a, $urandom());
        end
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d queries and %0d inserts checked, %0d inserts refused on a full table",
             query_count, insert_count, drop_count);
    $display("summary: %0d saturated results, %0d rate settings, %0d mismatches",
             saturated_count, rate_writes, mismatch_count);
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
